// ===== hw/rtl/ipdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipdc_pkg;

    // Prescaler lengths in millisecond ticks.
    localparam int TICKS_PER_TENTH  = 100;
    localparam int TICKS_PER_SECOND = 1000;

    localparam int TP_W   = 7;   // tenth prescaler width
    localparam int SP_W   = 10;  // second prescaler width
    localparam int IDLE_W = 20;  // idle counter width, in tenths
    localparam int SEC_W  = 16;  // threshold register width, in seconds
    localparam int CD_W   = 4;   // countdown width
    localparam int EV_W   = 3;   // event code width
    localparam int STG_W  = 3;   // stage code width
    localparam int CIDX_W = 8;   // configuration index width
    localparam int CDAT_W = 16;  // configuration data width

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    // Register reset values.
    localparam logic [SEC_W-1:0] DEMO_WAIT_RST  = 16'd300;
    localparam logic [SEC_W-1:0] SLEEP_WAIT_RST = 16'd900;
    localparam logic [CD_W-1:0]  CD_START_RST   = 4'd10;

    // Operating stage codes. Codes above the model stage are unknown and
    // behave like the user stage.
    localparam logic [STG_W-1:0] STAGE_USER        = 3'd0;
    localparam logic [STG_W-1:0] STAGE_RUN         = 3'd1;
    localparam logic [STG_W-1:0] STAGE_AGING       = 3'd2;
    localparam logic [STG_W-1:0] STAGE_ENGINEERING = 3'd3;
    localparam logic [STG_W-1:0] STAGE_MODEL       = 3'd4;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_DEMO  = 2'd1,
        MODE_COUNT = 2'd2,
        MODE_SLEEP = 2'd3
    } t_mode;

    typedef enum logic [EV_W-1:0] {
        EV_NONE       = 3'd0,
        EV_ENTER_DEMO = 3'd1,
        EV_QUIT_DEMO  = 3'd2,
        EV_COUNT      = 3'd3,
        EV_QUIT_COUNT = 3'd4,
        EV_SLEEP      = 3'd5,
        EV_STANDBY    = 3'd6
    } t_event;

    typedef enum logic [CIDX_W-1:0] {
        CFG_DEMO_WAIT   = 8'd0,
        CFG_SLEEP_WAIT  = 8'd1,
        CFG_ENERGY_SAVE = 8'd2,
        CFG_CD_START    = 8'd3
    } t_cfg_idx;

    // Seconds to tenths: x*8 + x*2, which always fits in the idle width.
    function automatic logic [IDLE_W-1:0] sec_to_tenths(input logic [SEC_W-1:0] sec);
        logic [IDLE_W-1:0] ext;
        ext = {{(IDLE_W-SEC_W){1'b0}}, sec};
        return (ext << 3) + (ext << 1);
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/inactivity_power_down_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Flow: a beat accepted into the input register has its result registered in the result
// register when it moves on; an output stall with a full result register holds it back.
// Throughput: one beat per cycle unless the receiver stalls, set by the mode and
// counter update done for each beat.
// Reset: synchronous, active low; empties both registers, sets idle mode, clears the
// idle counter, prescalers and flags, and loads the configuration reset values.
module inactivity_power_down_controller_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // Input channel
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire                          i_tick_1ms,
    input  wire  [ipdc_pkg::STG_W-1:0]   i_stage,
    input  wire                          i_key_pressed,
    input  wire                          i_quick_in,
    // Result channel
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [ipdc_pkg::EV_W-1:0]    o_event_res,
    output logic [ipdc_pkg::CD_W-1:0]    o_countdown_value,
    // Configuration write channel
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [ipdc_pkg::CIDX_W-1:0]  i_cfg_index,
    input  wire  [ipdc_pkg::CDAT_W-1:0]  i_cfg_data
);

    localparam int TP_W   = ipdc_pkg::TP_W;
    localparam int SP_W   = ipdc_pkg::SP_W;
    localparam int IDLE_W = ipdc_pkg::IDLE_W;
    localparam int CD_W   = ipdc_pkg::CD_W;
    localparam int SEC_W  = ipdc_pkg::SEC_W;

    // ------------------------------------------------------------------
    // Configuration. Thresholds are kept already scaled to tenths, so the
    // per-beat path only has to compare.
    // ------------------------------------------------------------------
    logic [IDLE_W-1:0] r_demo_thr;
    logic [IDLE_W-1:0] r_sleep_thr;
    logic              r_energy_en;
    logic [CD_W-1:0]   r_cd_start;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_demo_thr  <= ipdc_pkg::sec_to_tenths(ipdc_pkg::DEMO_WAIT_RST);
            r_sleep_thr <= ipdc_pkg::sec_to_tenths(ipdc_pkg::SLEEP_WAIT_RST);
            r_energy_en <= 1'b1;
            r_cd_start  <= ipdc_pkg::CD_START_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ipdc_pkg::CFG_DEMO_WAIT: begin
                    r_demo_thr <= ipdc_pkg::sec_to_tenths(i_cfg_data[SEC_W-1:0]);
                end
                ipdc_pkg::CFG_SLEEP_WAIT: begin
                    r_sleep_thr <= ipdc_pkg::sec_to_tenths(i_cfg_data[SEC_W-1:0]);
                end
                ipdc_pkg::CFG_ENERGY_SAVE: begin
                    r_energy_en <= i_cfg_data[0];
                end
                ipdc_pkg::CFG_CD_START: begin
                    r_cd_start <= i_cfg_data[CD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake. The input register can take a new beat whenever it is empty
    // or its beat moves into the result register, so a waiting result does
    // not block the upstream side until both registers are full.
    // ------------------------------------------------------------------
    logic                        r_in_valid;
    logic                        r_in_tick;
    logic [ipdc_pkg::STG_W-1:0]  r_in_stage;
    logic                        r_in_key;
    logic                        r_in_quick;
    logic                        r_out_valid;
    logic                        w_step;
    logic                        w_load;

    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_load) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_in_tick  <= i_tick_1ms;
            r_in_stage <= i_stage;
            r_in_key   <= i_key_pressed;
            r_in_quick <= i_quick_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Controller state.
    // ------------------------------------------------------------------
    ipdc_pkg::t_mode   r_mode,  n_mode;
    logic [IDLE_W-1:0] r_idle,  n_idle;
    logic [CD_W-1:0]   r_cd,    n_cd;
    logic [TP_W-1:0]   r_tp,    n_tp;
    logic [SP_W-1:0]   r_sp,    n_sp;
    logic              r_tf,    n_tf;
    logic              r_sf,    n_sf;

    // Prescalers first: the tick is counted before anything else looks at
    // the flags.
    logic [TP_W:0]     w_tp_sum;
    logic [SP_W:0]     w_sp_sum;
    logic [TP_W-1:0]   w_tp;
    logic [SP_W-1:0]   w_sp;
    logic              w_tf;
    logic              w_sf;

    always_comb begin
        w_tp_sum = {1'b0, r_tp} + (TP_W+1)'(1);
        w_sp_sum = {1'b0, r_sp} + (SP_W+1)'(1);
        w_tp = r_tp;
        w_sp = r_sp;
        w_tf = r_tf;
        w_sf = r_sf;
        if (r_in_tick) begin
            if (w_tp_sum >= (TP_W+1)'(ipdc_pkg::TICKS_PER_TENTH)) begin
                w_tp = '0;
                w_tf = 1'b1;
            end else begin
                w_tp = w_tp_sum[TP_W-1:0];
            end
            if (w_sp_sum >= (SP_W+1)'(ipdc_pkg::TICKS_PER_SECOND)) begin
                w_sp = '0;
                w_sf = 1'b1;
            end else begin
                w_sp = w_sp_sum[SP_W-1:0];
            end
        end
    end

    // Quick-in jumps the idle time to the sleep threshold. A key in idle mode
    // restarts the idle time before the tenth check sees it.
    logic [IDLE_W-1:0] w_idle_q;
    logic [IDLE_W-1:0] w_idle_x;
    logic [IDLE_W-1:0] w_idle_inc;
    logic              w_protect;
    logic              w_sleep_due;
    logic              w_demo_due;
    logic              w_cd_more;
    logic [CD_W-1:0]   w_cd_dec;

    always_comb begin
        w_idle_q  = r_in_quick ? r_sleep_thr : r_idle;
        // Program run, aging test, engineering and model hold the block in idle,
        // except that engineering gives way once the demo threshold is passed.
        w_protect = (r_in_stage >= ipdc_pkg::STAGE_RUN) &&
                    (r_in_stage <= ipdc_pkg::STAGE_MODEL) &&
                    !((r_in_stage == ipdc_pkg::STAGE_ENGINEERING) &&
                      (w_idle_q > r_demo_thr));
        w_idle_x  = ((r_mode == ipdc_pkg::MODE_IDLE) && r_in_key) ? '0 : w_idle_q;
        w_idle_inc  = (w_idle_x == ipdc_pkg::IDLE_MAX) ? w_idle_x
                                                        : w_idle_x + IDLE_W'(1);
        w_sleep_due = r_energy_en && (w_idle_x >= r_sleep_thr);
        w_demo_due  = w_idle_x >= r_demo_thr;
        w_cd_more   = r_cd > CD_W'(1);
        w_cd_dec    = r_cd - CD_W'(1);
    end

    // Next state.
    always_comb begin
        n_mode = r_mode;
        n_idle = w_idle_x;
        n_cd   = r_cd;
        n_tp   = w_tp;
        n_sp   = w_sp;
        n_tf   = w_tf;
        n_sf   = w_sf;
        if (w_protect) begin
            n_idle = '0;
            n_mode = ipdc_pkg::MODE_IDLE;
            if (r_mode == ipdc_pkg::MODE_COUNT) begin
                n_cd = r_cd_start;
            end
        end else begin
            unique case (r_mode)
                ipdc_pkg::MODE_IDLE: begin
                    if (w_tf) begin
                        n_tf = 1'b0;
                        if (w_sleep_due) begin
                            n_sf   = 1'b0;
                            n_sp   = '0;
                            n_mode = ipdc_pkg::MODE_COUNT;
                        end else if (w_demo_due) begin
                            n_mode = ipdc_pkg::MODE_DEMO;
                        end else begin
                            n_idle = w_idle_inc;
                        end
                    end
                end
                ipdc_pkg::MODE_DEMO: begin
                    if (r_in_key) begin
                        n_idle = '0;
                        n_tf   = 1'b0;
                        n_mode = ipdc_pkg::MODE_IDLE;
                    end else if (w_tf) begin
                        n_tf = 1'b0;
                        if (w_sleep_due) begin
                            n_sf   = 1'b0;
                            n_sp   = '0;
                            n_mode = ipdc_pkg::MODE_COUNT;
                        end else begin
                            n_idle = w_idle_inc;
                        end
                    end
                end
                ipdc_pkg::MODE_COUNT: begin
                    if (r_in_key) begin
                        n_sf   = 1'b0;
                        n_idle = '0;
                        n_cd   = r_cd_start;
                        n_mode = ipdc_pkg::MODE_IDLE;
                    end else if (w_sf) begin
                        n_sf = 1'b0;
                        n_sp = '0;
                        if (w_cd_more) begin
                            n_cd = w_cd_dec;
                        end else begin
                            n_cd   = r_cd_start;
                            n_mode = ipdc_pkg::MODE_SLEEP;
                        end
                    end
                end
                ipdc_pkg::MODE_SLEEP: begin
                    // Any user-stage beat after sleep reports the standby request.
                    n_idle = '0;
                    n_sp   = '0;
                    n_sf   = 1'b0;
                    n_mode = ipdc_pkg::MODE_IDLE;
                end
                default: begin
                end
            endcase
        end
    end

    // Result of the beat.
    ipdc_pkg::t_event  w_ev;
    logic [CD_W-1:0]   w_val;

    always_comb begin
        w_ev  = ipdc_pkg::EV_NONE;
        w_val = '0;
        if (!w_protect) begin
            unique case (r_mode)
                ipdc_pkg::MODE_IDLE: begin
                    if (w_tf) begin
                        if (w_sleep_due) begin
                            w_ev  = ipdc_pkg::EV_COUNT;
                            w_val = r_cd;
                        end else if (w_demo_due) begin
                            w_ev = ipdc_pkg::EV_ENTER_DEMO;
                        end
                    end
                end
                ipdc_pkg::MODE_DEMO: begin
                    if (r_in_key) begin
                        w_ev = ipdc_pkg::EV_QUIT_DEMO;
                    end else if (w_tf && w_sleep_due) begin
                        w_ev  = ipdc_pkg::EV_COUNT;
                        w_val = r_cd;
                    end
                end
                ipdc_pkg::MODE_COUNT: begin
                    if (r_in_key) begin
                        w_ev = ipdc_pkg::EV_QUIT_COUNT;
                    end else if (w_sf) begin
                        if (w_cd_more) begin
                            w_ev  = ipdc_pkg::EV_COUNT;
                            w_val = w_cd_dec;
                        end else begin
                            w_ev = ipdc_pkg::EV_SLEEP;
                        end
                    end
                end
                ipdc_pkg::MODE_SLEEP: begin
                    w_ev = ipdc_pkg::EV_STANDBY;
                end
                default: begin
                end
            endcase
        end
    end

    // State only advances when a beat moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ipdc_pkg::MODE_IDLE;
            r_idle <= '0;
            r_cd   <= ipdc_pkg::CD_START_RST;
            r_tp   <= '0;
            r_sp   <= '0;
            r_tf   <= 1'b0;
            r_sf   <= 1'b0;
        end else if (w_step) begin
            r_mode <= n_mode;
            r_idle <= n_idle;
            r_cd   <= n_cd;
            r_tp   <= n_tp;
            r_sp   <= n_sp;
            r_tf   <= n_tf;
            r_sf   <= n_sf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            o_event_res       <= w_ev;
            o_countdown_value <= w_val;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== hw/rtl/ipdc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipdc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          o_in_stall,
    input wire                          o_out_valid,
    input wire                          i_out_stall,
    input wire [ipdc_pkg::EV_W-1:0]     o_event_res,
    input wire [ipdc_pkg::CD_W-1:0]     o_countdown_value
);

    // A held result keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_event_res) && $stable(o_countdown_value))
        else $error("result changed while stalled");

    // Upstream is only held off when a finished result is waiting downstream.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a waiting result");

    // The countdown number is shown only with the countdown event.
    a_cd_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_res != ipdc_pkg::EV_COUNT) |-> o_countdown_value == '0)
        else $error("countdown value without countdown event");

    // Event codes stay within the defined set.
    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_event_res <= ipdc_pkg::EV_STANDBY)
        else $error("undefined event code");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("result valid after reset");

endmodule

bind inactivity_power_down_controller_unit ipdc_checker u_ipdc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_event_res       (o_event_res),
    .o_countdown_value (o_countdown_value)
);

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ipdc_pkg::*;

    localparam int IDLE_TOP     = int'(IDLE_MAX);
    localparam int HOLD_CYCLES  = 60;    // long receiver hold-off in the pressure test
    localparam int STALL_LIMIT  = 4000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES = 8;     // extra wait after the last result; leave margin

    typedef struct packed {
        t_event          ev;
        logic [CD_W-1:0] value;
    } t_power_event;

    // Ports of the block. Every input starts at a known value.
    logic                 i_clk;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic                 i_tick_1ms     = 1'b0;
    logic [STG_W-1:0]     i_stage        = '0;
    logic                 i_key_pressed  = 1'b0;
    logic                 i_quick_in     = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic [EV_W-1:0]      o_event_res;
    logic [CD_W-1:0]      o_countdown_value;
    logic                 i_cfg_valid    = 1'b0;
    logic                 o_cfg_ready;
    logic [CIDX_W-1:0]    i_cfg_index    = '0;
    logic [CDAT_W-1:0]    i_cfg_data     = '0;

    // Shadow copy of the configuration registers, starting at their reset values.
    logic [SEC_W-1:0]     demo_after_s   = DEMO_WAIT_RST;
    logic [SEC_W-1:0]     sleep_after_s  = SLEEP_WAIT_RST;
    logic                 saver_on       = 1'b1;
    logic [CD_W-1:0]      count_from     = CD_START_RST;

    // Shadow copy of the controller state.
    t_mode                pwr_mode       = MODE_IDLE;
    int                   idle_time      = 0;   // idle time in tenths of a second
    logic [CD_W-1:0]      shown_count    = CD_START_RST;
    int                   ms_in_tenth    = 0;
    int                   ms_in_second   = 0;
    logic                 tenth_pending  = 1'b0;
    logic                 second_pending = 1'b0;

    // Events predicted for accepted beats, oldest first.
    t_power_event         pending_events[$];
    int                   fail_count     = 0;
    int                   quiet_cycles   = 0;

    // Traffic shaping. The sender flag is only touched by the stimulus process;
    // the receiver flag and the hold request are handed over with nonblocking
    // writes so the receiver process sees them at a well-defined edge.
    bit                   sender_idles   = 1'b1;
    logic                 receiver_idles = 1'b1;
    logic                 hold_toggle    = 1'b0;
    logic                 hold_seen      = 1'b0;
    int                   hold_left      = 0;

    inactivity_power_down_controller_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_tick_1ms        (i_tick_1ms),
        .i_stage           (i_stage),
        .i_key_pressed     (i_key_pressed),
        .i_quick_in        (i_quick_in),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_event_res       (o_event_res),
        .o_countdown_value (o_countdown_value),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Behavioral prediction of the controller.
    // ------------------------------------------------------------------

    // Power-down is due once the saver is enabled and the idle time has reached
    // the sleep threshold, which is held in seconds and compared in tenths.
    function automatic bit sleep_threshold_met();
        return saver_on && (idle_time >= int'(sleep_after_s) * 10);
    endfunction

    // Starting the countdown restarts the second prescaler so the first
    // visible number stays up for a full second.
    task automatic begin_countdown(output t_event ev, output logic [CD_W-1:0] val);
        second_pending = 1'b0;
        ms_in_second   = 0;
        pwr_mode       = MODE_COUNT;
        ev             = EV_COUNT;
        val            = shown_count;
    endtask

    // Any exit from the countdown reloads it, which is also the only point where
    // a new countdown start value becomes visible.
    task automatic return_to_idle();
        if (pwr_mode == MODE_COUNT) begin
            shown_count = count_from;
        end
        pwr_mode = MODE_IDLE;
    endtask

    task automatic predict_power_event(
        input  logic             tick,
        input  logic [STG_W-1:0] stage_code,
        input  logic             key,
        input  logic             quick,
        output t_power_event     result
    );
        logic [STG_W-1:0] stage;
        t_event           ev;
        logic [CD_W-1:0]  val;
        ev    = EV_NONE;
        val   = '0;
        stage = stage_code;

        // The millisecond tick is applied first; both flags stay pending until
        // the mode logic consumes them.
        if (tick) begin
            ms_in_tenth++;
            if (ms_in_tenth >= TICKS_PER_TENTH) begin
                ms_in_tenth   = 0;
                tenth_pending = 1'b1;
            end
            ms_in_second++;
            if (ms_in_second >= TICKS_PER_SECOND) begin
                ms_in_second   = 0;
                second_pending = 1'b1;
            end
        end

        // Quick-in jumps the idle time straight to the sleep threshold.
        if (quick) begin
            idle_time = int'(sleep_after_s) * 10;
        end

        // The engineering stage loses its protection once the idle time has
        // passed the demo threshold.
        if (stage == STAGE_ENGINEERING && idle_time > int'(demo_after_s) * 10) begin
            stage = STAGE_USER;
        end

        if (stage >= STAGE_RUN && stage <= STAGE_MODEL) begin
            idle_time = 0;
            return_to_idle();
        end else begin
            case (pwr_mode)
                MODE_IDLE: begin
                    if (key) begin
                        idle_time = 0;
                    end
                    if (tenth_pending) begin
                        tenth_pending = 1'b0;
                        if (sleep_threshold_met()) begin
                            begin_countdown(ev, val);
                        end else if (idle_time >= int'(demo_after_s) * 10) begin
                            pwr_mode = MODE_DEMO;
                            ev       = EV_ENTER_DEMO;
                        end else if (idle_time < IDLE_TOP) begin
                            idle_time++;
                        end
                    end
                end
                MODE_DEMO: begin
                    if (key) begin
                        idle_time     = 0;
                        tenth_pending = 1'b0;
                        pwr_mode      = MODE_IDLE;
                        ev            = EV_QUIT_DEMO;
                    end else if (tenth_pending) begin
                        tenth_pending = 1'b0;
                        if (sleep_threshold_met()) begin
                            begin_countdown(ev, val);
                        end else if (idle_time < IDLE_TOP) begin
                            idle_time++;
                        end
                    end
                end
                MODE_COUNT: begin
                    if (key) begin
                        second_pending = 1'b0;
                        idle_time      = 0;
                        return_to_idle();
                        ev             = EV_QUIT_COUNT;
                    end else if (second_pending) begin
                        second_pending = 1'b0;
                        ms_in_second   = 0;
                        // A number of one (or zero) ends the countdown.
                        if (shown_count > 1) begin
                            shown_count--;
                            ev  = EV_COUNT;
                            val = shown_count;
                        end else begin
                            shown_count = count_from;
                            pwr_mode    = MODE_SLEEP;
                            ev          = EV_SLEEP;
                        end
                    end
                end
                default: begin
                    // First user-stage beat after sleep asks for standby.
                    idle_time      = 0;
                    ms_in_second   = 0;
                    second_pending = 1'b0;
                    pwr_mode       = MODE_IDLE;
                    ev             = EV_STANDBY;
                end
            endcase
        end

        result.ev    = ev;
        result.value = val;
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers. All of them are entered right after a rising edge and
    // drive with nonblocking writes, so the block sees stable values.
    // ------------------------------------------------------------------

    // Offers one beat and holds it until accepted, then records its event. The
    // valid is dropped only in the random idle gaps, so otherwise back-to-back beats keep it high.
    task automatic send_sample(
        input logic             tick,
        input logic [STG_W-1:0] stage,
        input logic             key,
        input logic             quick
    );
        t_power_event predicted;
        while (sender_idles && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_tick_1ms    <= tick;
        i_stage       <= stage;
        i_key_pressed <= key;
        i_quick_in    <= quick;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_power_event(tick, stage, key, quick, predicted);
        pending_events.push_back(predicted);
    endtask

    // Random beats. Percentages set how often a tick, a key, a quick-in and a
    // protected stage occur; the remaining stages are user or unknown codes.
    task automatic send_random(
        input int count,
        input int tick_pct,
        input int key_pct,
        input int quick_pct,
        input int guard_pct
    );
        logic [STG_W-1:0] stage;
        repeat (count) begin
            if ($urandom_range(99) < guard_pct) begin
                stage = STG_W'($urandom_range(int'(STAGE_RUN), int'(STAGE_MODEL)));
            end else if ($urandom_range(3) == 0) begin
                stage = STG_W'($urandom_range(int'(STAGE_MODEL) + 1, (1 << STG_W) - 1));
            end else begin
                stage = STAGE_USER;
            end
            send_sample($urandom_range(99) < tick_pct, stage,
                        $urandom_range(99) < key_pct, $urandom_range(99) < quick_pct);
        end
    endtask

    // Drops the input valid and waits until every predicted event has arrived.
    task automatic await_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_events.size() != 0);
    endtask

    // One register write. The valid is left high so that consecutive writes
    // do not lower and raise it in the same step.
    task automatic write_reg(input t_cfg_idx idx, input logic [CDAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_DEMO_WAIT:   demo_after_s  = data;
            CFG_SLEEP_WAIT:  sleep_after_s = data;
            CFG_ENERGY_SAVE: saver_on      = data[0];
            CFG_CD_START:    count_from    = data[CD_W-1:0];
            default: ;
        endcase
    endtask

    // Every beat yields exactly one event, so once the queue is empty the block
    // has nothing in flight and may be reprogrammed.
    task automatic load_settings(
        input logic [SEC_W-1:0] demo_s,
        input logic [SEC_W-1:0] sleep_s,
        input logic             saver,
        input logic [CD_W-1:0]  start
    );
        await_all_results();
        write_reg(CFG_DEMO_WAIT, demo_s);
        write_reg(CFG_SLEEP_WAIT, sleep_s);
        write_reg(CFG_ENERGY_SAVE, {{(CDAT_W-1){1'b0}}, saver});
        write_reg(CFG_CD_START, {{(CDAT_W-CD_W){1'b0}}, start});
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset configuration: every stage code with key and quick-in patterns,
    // then the engineering stage on both sides of the demo threshold.
    task automatic test_field_extremes();
        logic [STG_W-1:0] stage;
        for (int s = 0; s < (1 << STG_W); s++) begin
            stage = STG_W'(s);
            send_sample(1'b1, stage, stage[0], stage[1]);
        end
        send_sample(1'b0, STAGE_USER, 1'b0, 1'b0);
        // Quick-in lifts idle time above the demo threshold: engineering acts as user.
        send_sample(1'b1, STAGE_ENGINEERING, 1'b0, 1'b1);
        send_sample(1'b0, STAGE_ENGINEERING, 1'b0, 1'b0);
        // A key clears idle time, after which engineering is protected again.
        send_sample(1'b0, STAGE_ENGINEERING, 1'b1, 1'b0);
        send_sample(1'b0, STAGE_ENGINEERING, 1'b0, 1'b0);
        send_sample(1'b1, STAGE_AGING, 1'b1, 1'b1);
        send_sample(1'b0, STAGE_MODEL, 1'b0, 1'b1);
        send_sample(1'b1, STAGE_RUN, 1'b1, 1'b0);
        send_sample(1'b1, STAGE_USER, 1'b1, 1'b1);
    endtask

    // Default thresholds: only quick-in reaches the countdown here, and keys
    // or protected stages pull the block back out of it.
    task automatic test_idle_timeout_defaults();
        send_random(120, 90, 3, 5, 5);
    endtask

    // The receiver holds off for a long stretch while the sender keeps pushing,
    // so the block fills and stalls its input. The threshold of one second with
    // quick-in brings a countdown that still shows the old start value.
    task automatic test_backpressure();
        load_settings(16'hFFFF, 16'd1, 1'b1, 4'd2);
        hold_toggle <= ~hold_toggle;
        sender_idles = 1'b0;
        send_random(40, 90, 0, 10, 0);
        sender_idles = 1'b1;
        send_random(100, 90, 3, 6, 5);
    endtask

    // Energy saver off with a zero demo threshold: demo is entered on the first
    // tenth in idle and left on keys; the sender pauses once until all events are in.
    task automatic test_demo_without_saver();
        load_settings(16'd0, 16'hFFFF, 1'b0, 4'd15);
        send_random(70, 90, 5, 3, 6);
        await_all_results();
        send_random(70, 90, 5, 3, 6);
    endtask

    // Zero thresholds: the countdown starts on the first tenth and still shows
    // an older number. A protected stage forces a reload of the start value of
    // one, then a clean run without keys ends the countdown on the next second,
    // enters sleep and asks for standby. The first part runs with no idling on
    // either side.
    task automatic test_sleep_and_standby();
        load_settings(16'd0, 16'd0, 1'b1, 4'd1);
        receiver_idles <= 1'b0;
        sender_idles = 1'b0;
        send_random(120, 99, 0, 3, 0);
        send_sample(1'b1, STAGE_RUN, 1'b0, 1'b0);
        send_random(700, 99, 0, 3, 0);
        receiver_idles <= 1'b1;
        sender_idles = 1'b1;
        send_random(460, 99, 0, 3, 0);
        // Random noise after the standby request.
        send_random(80, 90, 5, 3, 8);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_idle_timeout_defaults();
        test_backpressure();
        test_demo_without_saver();
        test_sleep_and_standby();

        await_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[inactivity_power_down_controller_unit] OK");
        end else begin
            $display("[inactivity_power_down_controller_unit] ERROR");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, a long hold-off on request, and stretches
    // with no stalls at all.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_toggle != hold_seen) begin
            hold_seen   <= hold_toggle;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= receiver_idles && ($urandom_range(99) < 19);
        end
    end

    // Every accepted result is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_power_event wanted;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_events.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected event beat: event %0d countdown %0d",
                             o_event_res, o_countdown_value);
                end
                fail_count++;
            end else begin
                wanted = pending_events.pop_front();
                if (o_event_res !== wanted.ev || o_countdown_value !== wanted.value) begin
                    if (fail_count < 10) begin
                        $display("mismatch: event exp %0d got %0d, countdown exp %0d got %0d",
                                 wanted.ev, o_event_res, wanted.value, o_countdown_value);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[inactivity_power_down_controller_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== inactivity_power_down_controller_unit.f =====
hw/rtl/ipdc_pkg.sv
hw/rtl/inactivity_power_down_controller_unit.sv
hw/rtl/ipdc_checker.sv
verif/tb.sv
